// ===== rtl/lidar_frame_parse_average_assert.svh =====
// assertion macros used by the averaging rtl
`ifndef LIDAR_FRAME_PARSE_AVERAGE_ASSERT_SVH
`define LIDAR_FRAME_PARSE_AVERAGE_ASSERT_SVH

// same-cycle implication
`define LFPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LFPA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lfpa_pkg.sv =====
// shared constants, codes and types of the lidar frame parser and averager
package lfpa_pkg;

    localparam int LFPA_MAX_WINDOW = 128;
    localparam int FRAME_LENGTH    = 9;
    localparam int BYTE_IDX_W      = $clog2(FRAME_LENGTH);
    localparam int BYTE_SEL_W      = $clog2(FRAME_LENGTH - 1);
    localparam int AVG_W           = 24;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;

    localparam logic [7:0]  SYNC_BYTE    = 8'h59;
    localparam logic [7:0]  WINDOW_RESET = 8'd100;
    localparam logic [15:0] PERIOD_RESET = 16'd6000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LENGTH  = 2'd0,
        CFG_PUBLISH_PERIOD = 2'd1
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_BAD_SYNC = 2'd1,
        ST_BAD_SUM  = 2'd2
    } t_status;

    typedef struct packed {
        logic        valid;
        t_status     status;
        logic [15:0] distance;
        logic [15:0] strength;
    } t_frame;

    typedef struct packed {
        logic        clear;
        logic [7:0]  window_length;
        logic [15:0] publish_period;
    } t_cfg;

    typedef struct packed {
        t_status          status;
        logic             publish;
        logic [15:0]      raw_distance;
        logic [15:0]      raw_strength;
        logic [AVG_W-1:0] avg_distance;
        logic [AVG_W-1:0] avg_strength;
    } t_result;

endpackage

// ===== rtl/lfpa_if.sv =====
// valid/ready channel interfaces for bytes, results and configuration writes
interface lfpa_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface lfpa_result_if import lfpa_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [1:0]       frame_status;
    logic             publish;
    logic [15:0]      raw_distance;
    logic [15:0]      raw_strength;
    logic [AVG_W-1:0] avg_distance;
    logic [AVG_W-1:0] avg_strength;

    modport source (output valid, output frame_status, output publish, output raw_distance,
                    output raw_strength, output avg_distance, output avg_strength,
                    input ready);
    modport sink (input valid, input frame_status, input publish, input raw_distance,
                  input raw_strength, input avg_distance, input avg_strength,
                  output ready);
endinterface

interface lfpa_cfg_if import lfpa_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/lfpa_parse.sv =====
// byte framer: sync hunt, frame gathering and checksum check
module lfpa_parse import lfpa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    output t_frame     o_frame
);

    logic                  r_in_frame;
    logic [BYTE_IDX_W-1:0] r_idx;
    logic [7:0]            r_sum;
    logic [7:0]            r_bytes [FRAME_LENGTH-1];
    t_frame                r_frame;
    t_status               n_status;
    logic                  gathering;

    assign gathering = r_in_frame && (r_idx < BYTE_IDX_W'(FRAME_LENGTH - 1));

    always_comb begin
        if (r_bytes[1] != SYNC_BYTE) begin
            n_status = ST_BAD_SYNC;
        end else if (r_sum != i_rx_byte) begin
            n_status = ST_BAD_SUM;
        end else begin
            n_status = ST_VALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && gathering) begin
            r_bytes[r_idx[BYTE_SEL_W-1:0]] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame    <= 1'b0;
            r_idx         <= '0;
            r_sum         <= '0;
            r_frame.valid <= 1'b0;
        end else begin
            r_frame.valid <= i_accept && r_in_frame && !gathering;
            if (i_accept) begin
                if (!r_in_frame) begin
                    if (i_rx_byte == SYNC_BYTE) begin
                        r_in_frame <= 1'b1;
                        r_sum      <= i_rx_byte;
                        r_idx      <= BYTE_IDX_W'(1);
                    end
                end else if (gathering) begin
                    r_sum <= r_sum + i_rx_byte;
                    r_idx <= r_idx + BYTE_IDX_W'(1);
                end else begin
                    r_in_frame       <= 1'b0;
                    r_idx            <= '0;
                    r_sum            <= '0;
                    r_frame.status   <= n_status;
                    r_frame.distance <= {r_bytes[3], r_bytes[2]};
                    r_frame.strength <= {r_bytes[5], r_bytes[4]};
                end
            end
        end
    end

    assign o_frame = r_frame;

endmodule

// ===== rtl/lfpa_div.sv =====
// shared restoring divider, one quotient bit per cycle
module lfpa_div #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign rem_sh = {r_rem, r_quo[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNT_W'(NUM_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], ge};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/lfpa_avg.sv =====
// moving-average windows, publish counter and result sequencer
`include "lidar_frame_parse_average_assert.svh"
module lfpa_avg import lfpa_pkg::*; #(
    parameter int MAX_WINDOW = LFPA_MAX_WINDOW
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_frame  i_frame,
    input  t_cfg    i_cfg,
    input  logic    i_out_free,
    output logic    o_idle,
    output logic    o_load,
    output t_result o_result
);

    localparam int ADDR_W = $clog2(MAX_WINDOW);
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int TOT_W  = 16 + ADDR_W;
    localparam int NUM_W  = TOT_W + 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUB,
        S_COUNT,
        S_DIV_D,
        S_DIV_S,
        S_FINISH
    } t_state;

    t_state            r_state;
    logic [LEN_W-1:0]  r_fill;
    logic [ADDR_W-1:0] r_oldest;
    logic [TOT_W-1:0]  r_tot_d;
    logic [TOT_W-1:0]  r_tot_s;
    logic [15:0]       r_fsp;
    logic [15:0]       r_dist;
    logic [15:0]       r_str;
    t_result           r_result;
    logic [31:0]       r_mem [MAX_WINDOW];
    logic [31:0]       r_rd_data;

    logic [31:0]       wl_ext;
    logic [31:0]       len_ext;
    logic [LEN_W-1:0]  eff_len;
    logic              full;
    logic [LEN_W:0]    slot_sum;
    logic [LEN_W:0]    slot_wrap;
    logic [ADDR_W-1:0] fill_slot;
    logic [LEN_W-1:0]  oldest_inc;
    logic [ADDR_W-1:0] oldest_next;
    logic [15:0]       fsp_inc;
    logic              pub_now;
    logic              take_frame;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [31:0]       mem_wdata;
    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic              div_done;
    logic [NUM_W-1:0]  div_quo;

    always_comb begin
        wl_ext = 32'(i_cfg.window_length);
        if (wl_ext == 32'd0) begin
            len_ext = 32'd1;
        end else if (wl_ext > 32'(MAX_WINDOW)) begin
            len_ext = 32'(MAX_WINDOW);
        end else begin
            len_ext = wl_ext;
        end
    end

    assign eff_len     = len_ext[LEN_W-1:0];
    assign full        = r_fill >= eff_len;
    assign slot_sum    = (LEN_W+1)'(r_oldest) + (LEN_W+1)'(r_fill);
    assign slot_wrap   = (slot_sum >= {1'b0, eff_len}) ? slot_sum - {1'b0, eff_len} : slot_sum;
    assign fill_slot   = slot_wrap[ADDR_W-1:0];
    assign oldest_inc  = LEN_W'(r_oldest) + LEN_W'(1);
    assign oldest_next = (oldest_inc == eff_len) ? '0 : oldest_inc[ADDR_W-1:0];
    assign fsp_inc     = r_fsp + 16'd1;
    assign pub_now     = fsp_inc >= i_cfg.publish_period;
    assign take_frame  = (r_state == S_IDLE) && i_frame.valid && (i_frame.status == ST_VALID);

    assign mem_we    = (take_frame && !full) || (r_state == S_SUB);
    assign mem_addr  = (r_state == S_SUB) ? r_oldest : fill_slot;
    assign mem_wdata = (r_state == S_SUB) ? {r_str, r_dist} : {i_frame.strength, i_frame.distance};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_oldest];
    end

    assign div_start = ((r_state == S_COUNT) && pub_now) || ((r_state == S_DIV_D) && div_done);
    assign div_num   = (r_state == S_COUNT) ? {r_tot_d, 8'd0} : {r_tot_s, 8'd0};

    lfpa_div #(
        .NUM_W (NUM_W),
        .DEN_W (LEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_num      (div_num),
        .i_den      (r_fill),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_oldest <= '0;
            r_tot_d  <= '0;
            r_tot_s  <= '0;
            r_fsp    <= '0;
        end else if (i_cfg.clear) begin
            r_fill   <= '0;
            r_oldest <= '0;
            r_tot_d  <= '0;
            r_tot_s  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_frame.valid) begin
                        r_result.status       <= i_frame.status;
                        r_result.publish      <= 1'b0;
                        r_result.avg_distance <= '0;
                        r_result.avg_strength <= '0;
                        if (i_frame.status == ST_VALID) begin
                            r_result.raw_distance <= i_frame.distance;
                            r_result.raw_strength <= i_frame.strength;
                            r_dist <= i_frame.distance;
                            r_str  <= i_frame.strength;
                            if (!full) begin
                                r_fill  <= r_fill + LEN_W'(1);
                                r_tot_d <= r_tot_d + TOT_W'(i_frame.distance);
                                r_tot_s <= r_tot_s + TOT_W'(i_frame.strength);
                                r_state <= S_COUNT;
                            end else begin
                                r_state <= S_SUB;
                            end
                        end else begin
                            r_result.raw_distance <= '0;
                            r_result.raw_strength <= '0;
                            r_state               <= S_FINISH;
                        end
                    end
                end
                S_SUB: begin
                    r_tot_d  <= r_tot_d - TOT_W'(r_rd_data[15:0]) + TOT_W'(r_dist);
                    r_tot_s  <= r_tot_s - TOT_W'(r_rd_data[31:16]) + TOT_W'(r_str);
                    r_oldest <= oldest_next;
                    r_state  <= S_COUNT;
                end
                S_COUNT: begin
                    if (pub_now) begin
                        r_result.publish <= 1'b1;
                        r_fsp            <= '0;
                        r_state          <= S_DIV_D;
                    end else begin
                        r_fsp   <= fsp_inc;
                        r_state <= S_FINISH;
                    end
                end
                S_DIV_D: begin
                    if (div_done) begin
                        r_result.avg_distance <= div_quo[AVG_W-1:0];
                        r_state               <= S_DIV_S;
                    end
                end
                S_DIV_S: begin
                    if (div_done) begin
                        r_result.avg_strength <= div_quo[AVG_W-1:0];
                        r_state               <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle   = r_state == S_IDLE;
    assign o_load   = (r_state == S_FINISH) && i_out_free;
    assign o_result = r_result;

    `LFPA_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= eff_len,
        "fill count beyond window length")
    `LFPA_ASSERT_IMP(a_oldest_bound, i_clk, i_rst_n, 1'b1, LEN_W'(r_oldest) < eff_len,
        "oldest pointer outside window")
    `LFPA_ASSERT_NXT(a_bad_frame_skip, i_clk, i_rst_n,
        (r_state == S_IDLE) && i_frame.valid && (i_frame.status != ST_VALID),
        r_state == S_FINISH, "bad frame entered the averaging path")
    `LFPA_ASSERT_IMP(a_publish_valid, i_clk, i_rst_n,
        (r_state == S_FINISH) && r_result.publish, r_result.status == ST_VALID,
        "publish on a bad frame")

endmodule

// ===== rtl/lidar_frame_parse_average.sv =====
// top level of the lidar frame parser with moving averages
// channels: i_rx takes one serial byte per item, o_res gives one result per
// finished nine-byte frame, i_cfg writes window_length (index 0) and
// publish_period (index 1); a write to window_length empties both windows.
// a byte that does not end a frame leaves i_rx.ready high.
// a frame's last byte makes the block busy until its result is loaded into
// the output register: a bad frame goes straight to the finish state, a valid
// one passes the count state first, and when the window is full the oldest
// sample is read from the ring and subtracted first. a publishing frame adds
// two serial divisions, distance then strength, of a 24 + log2(MAX_WINDOW)
// bit numerator each; the divider gives one quotient bit per cycle.
// the ring buffers are one memory of MAX_WINDOW entries holding distance and
// strength side by side.
// results sit in an output register, so bytes are still taken while a result
// waits; once the next frame ends, its result is held in the sequencer and
// i_rx.ready stays low until the waiting result is taken.
// reset (synchronous, active low) returns to sync hunting, empties the
// windows and loads window_length 100 and publish_period 6000.
module lidar_frame_parse_average import lfpa_pkg::*; #(
    parameter int MAX_WINDOW = LFPA_MAX_WINDOW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lfpa_byte_if.sink     i_rx,
    lfpa_cfg_if.sink      i_cfg,
    lfpa_result_if.source o_res
);

    logic [7:0]  r_window_length;
    logic [15:0] r_publish_period;
    logic        r_out_valid;
    t_result     r_out;

    t_frame      frame;
    t_cfg        cfg;
    t_result     result;
    logic        avg_idle;
    logic        out_load;
    logic        out_free;
    logic        cfg_we;
    logic        rx_accept;

    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length  <= WINDOW_RESET;
            r_publish_period <= PERIOD_RESET;
        end else if (cfg_we) begin
            if (i_cfg.index == CFG_WINDOW_LENGTH) begin
                r_window_length <= i_cfg.data[7:0];
            end else if (i_cfg.index == CFG_PUBLISH_PERIOD) begin
                r_publish_period <= i_cfg.data;
            end
        end
    end

    assign cfg.clear          = cfg_we && (i_cfg.index == CFG_WINDOW_LENGTH);
    assign cfg.window_length  = r_window_length;
    assign cfg.publish_period = r_publish_period;

    assign i_rx.ready = avg_idle && !frame.valid;
    assign rx_accept  = i_rx.valid && i_rx.ready;

    lfpa_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (rx_accept),
        .i_rx_byte (i_rx.rx_byte),
        .o_frame   (frame)
    );

    assign out_free = !r_out_valid || o_res.ready;

    lfpa_avg #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_avg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_frame    (frame),
        .i_cfg      (cfg),
        .i_out_free (out_free),
        .o_idle     (avg_idle),
        .o_load     (out_load),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out       <= result;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.frame_status = r_out.status;
    assign o_res.publish      = r_out.publish;
    assign o_res.raw_distance = r_out.raw_distance;
    assign o_res.raw_strength = r_out.raw_strength;
    assign o_res.avg_distance = r_out.avg_distance;
    assign o_res.avg_strength = r_out.avg_strength;

endmodule
